// File: hw/rtl/kpv_pkg.sv
// Shared types, constants and helpers of the position/velocity Kalman estimator.
// Used by kpv_div and kalman_pos_vel_estimator_unit; depends on nothing else.
package kpv_pkg;

  localparam int DATA_W        = 32;
  localparam int NOISE_W       = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int SAT_W         = 72;

  // Scratch memory layout: 6x6 matrices with a row stride of 6, the augmented
  // inversion matrix with a row stride of 12.
  localparam int ADDR_W    = 8;
  localparam int MEM_DEPTH = 256;
  localparam int MAT_N     = 6;
  localparam int AUG_COLS  = 12;
  localparam logic [ADDR_W-1:0] P_BASE   = 8'd0;
  localparam logic [ADDR_W-1:0] T1_BASE  = 8'd36;
  localparam logic [ADDR_W-1:0] PP_BASE  = 8'd72;
  localparam logic [ADDR_W-1:0] AUG_BASE = 8'd108;
  localparam logic [ADDR_W-1:0] K_BASE   = 8'd180;

  localparam logic [1:0] REG_PROCESS_NOISE  = 2'd0;
  localparam logic [1:0] REG_POSITION_NOISE = 2'd1;
  localparam logic [1:0] REG_VELOCITY_NOISE = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRED,
    ST_MM_AP,
    ST_MM_PAT,
    ST_ADDQ,
    ST_BUILD,
    ST_PIV,
    ST_SWAP,
    ST_DIV,
    ST_ELIM_F,
    ST_ELIM,
    ST_MM_K,
    ST_XUPD,
    ST_MM_P,
    ST_FINISH
  } kpv_state_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(32'sh7FFFFFFF);
    lo = -SAT_W'(33'sh080000000);
    if (v > hi) return 32'sh7FFFFFFF;
    else if (v < lo) return 32'sh80000000;
    else return v[DATA_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] mat_addr(input logic [ADDR_W-1:0] base,
                                                 input logic [2:0] row,
                                                 input logic [3:0] col,
                                                 input logic wide);
    logic [ADDR_W-1:0] stride;
    stride = wide ? ADDR_W'(AUG_COLS) : ADDR_W'(MAT_N);
    return base + ADDR_W'(row) * stride + ADDR_W'(col);
  endfunction

endpackage

// File: hw/rtl/kpv_div.sv
// Serial fixed-point divider: rounded (a * 2^FRAC_BITS) / b, saturated to 32 bits.
// One quotient bit per cycle. Depends on kpv_pkg.
module kpv_div #(
  parameter int FRAC_BITS = kpv_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [kpv_pkg::DATA_W-1:0] num,
  input  logic signed [kpv_pkg::DATA_W-1:0] den,
  output logic                              done,
  output logic signed [kpv_pkg::DATA_W-1:0] quo
);
  import kpv_pkg::*;

  localparam int NW = DATA_W + 1 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [NW-1:0]     dvd;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dmag;
  logic              neg;
  logic [DATA_W-1:0] nmag_in;
  logic [DATA_W-1:0] dmag_in;
  logic [DATA_W:0]   rem_sh;
  logic              take;
  logic              big;

  always_comb begin
    nmag_in = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    dmag_in = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
    rem_sh  = {rem, dvd[NW-1]};
    take    = rem_sh >= {1'b0, dmag};
    big     = |dvd[NW-1:DATA_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        // Adding half the divisor up front gives round half away from zero.
        dvd  <= (NW'(nmag_in) << FRAC_BITS) + NW'(dmag_in >> 1);
        rem  <= '0;
        dmag <= dmag_in;
        neg  <= num[DATA_W-1] ^ den[DATA_W-1];
      end else if (busy) begin
        if (cnt == CW'(NW)) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) quo <= big ? 32'sh80000000 : -$signed(dvd[DATA_W-1:0]);
          else     quo <= big ? 32'sh7FFFFFFF : $signed(dvd[DATA_W-1:0]);
        end else begin
          dvd <= {dvd[NW-2:0], take};
          rem <= take ? DATA_W'(rem_sh - {1'b0, dmag}) : rem_sh[DATA_W-1:0];
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

endmodule

// File: hw/rtl/kalman_pos_vel_estimator_unit.sv
// Six-state constant-velocity Kalman estimator: sequencer, scratch memory and one
// shared multiply-accumulate unit. Depends on kpv_pkg and kpv_div.
// Four 6x6 products run on the multiply-accumulate unit, and the inversion needs 72 serial
// divisions, fewer when the innovation turns singular. One word is in work at a time; in_ready
// rises in the cycle after the result is loaded. After reset a clearing pass loads the
// identity covariance before in_ready rises.
module kalman_pos_vel_estimator_unit #(
  parameter int FRAC_BITS = kpv_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [kpv_pkg::DATA_W-1:0]  timestamp,
  input  logic signed [kpv_pkg::DATA_W-1:0]  pos_x,
  input  logic signed [kpv_pkg::DATA_W-1:0]  pos_y,
  input  logic signed [kpv_pkg::DATA_W-1:0]  pos_z,
  input  logic signed [kpv_pkg::DATA_W-1:0]  vel_x,
  input  logic signed [kpv_pkg::DATA_W-1:0]  vel_y,
  input  logic signed [kpv_pkg::DATA_W-1:0]  vel_z,
  input  logic signed [kpv_pkg::DATA_W-1:0]  acc_x,
  input  logic signed [kpv_pkg::DATA_W-1:0]  acc_y,
  input  logic signed [kpv_pkg::DATA_W-1:0]  acc_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic        [kpv_pkg::DATA_W-1:0]  out_time,
  output logic signed [kpv_pkg::DATA_W-1:0]  est_pos_x,
  output logic signed [kpv_pkg::DATA_W-1:0]  est_pos_y,
  output logic signed [kpv_pkg::DATA_W-1:0]  est_pos_z,
  output logic signed [kpv_pkg::DATA_W-1:0]  est_vel_x,
  output logic signed [kpv_pkg::DATA_W-1:0]  est_vel_y,
  output logic signed [kpv_pkg::DATA_W-1:0]  est_vel_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [1:0]                  cfg_index,
  input  logic        [kpv_pkg::NOISE_W-1:0] cfg_data
);
  import kpv_pkg::*;

  localparam int ACC_W = 68 - FRAC_BITS;
  localparam logic signed [DATA_W-1:0] FX_ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [63:0] HALF64 = 64'(1) << (FRAC_BITS - 1);
  localparam logic [NOISE_W-1:0] RESET_Q = NOISE_W'(((1 << FRAC_BITS) * 4 + 5) / 10);
  localparam logic [NOISE_W-1:0] RESET_R = NOISE_W'(((1 << FRAC_BITS) + 5) / 10);

  kpv_state_t state;
  kpv_state_t state_next;
  kpv_state_t follow;

  logic [2:0] i, i_next, ilast;
  logic [3:0] j, j_next, jlast;
  logic [2:0] k, k_next, klast;
  logic [1:0] ph, ph_next;
  logic [2:0] c, c_next;
  logic [2:0] r, r_next;
  logic [2:0] rn;

  logic [NOISE_W-1:0] process_noise;
  logic [NOISE_W-1:0] position_noise;
  logic [NOISE_W-1:0] velocity_noise;

  logic        [DATA_W-1:0] prev_time;
  logic        [DATA_W-1:0] tcur;
  logic        [DATA_W-1:0] dtu;
  logic signed [DATA_W-1:0] dt;
  logic signed [DATA_W-1:0] x   [MAT_N];
  logic signed [DATA_W-1:0] pre [MAT_N];
  logic signed [DATA_W-1:0] y   [MAT_N];
  logic signed [DATA_W-1:0] u   [3];

  logic [DATA_W-1:0]        mem [MEM_DEPTH];
  logic [ADDR_W-1:0]        addr_a, addr_b, wr_addr, dest_addr;
  logic signed [DATA_W-1:0] rda, rdb;
  logic                     wr_en;
  logic [DATA_W-1:0]        wr_data;

  logic                     eng;
  logic                     dest_mem;
  logic                     sub;
  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [33:0]       init_val;
  logic signed [63:0]       prod;
  logic signed [63:0]       rsum;
  logic signed [63:0]       rsh;
  logic signed [ACC_W-1:0]  rp;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] acc_sat;

  logic signed [DATA_W-1:0] f;
  logic signed [DATA_W-1:0] hold;
  logic signed [DATA_W-1:0] pv;
  logic [2:0]               best;
  logic [DATA_W:0]          bestmag;
  logic [DATA_W:0]          mag;
  logic                     singular;

  logic                     div_start;
  logic                     div_done;
  logic signed [DATA_W-1:0] div_q;

  logic signed [32:0]       zdiff;
  logic signed [32:0]       imk;
  logic signed [33:0]       rnoise;
  logic signed [DATA_W-1:0] ident_ik;

  logic in_acc;
  logic out_load;

  // Element (row, col) of the transition matrix [I dtI; 0 I].
  function automatic logic signed [DATA_W-1:0] amat(input logic [2:0] row,
                                                    input logic [2:0] col,
                                                    input logic signed [DATA_W-1:0] dtv);
    if (row == col) return FX_ONE;
    else if (row < 3'd3 && col == row + 3'd3) return dtv;
    else return '0;
  endfunction

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_load  = (state == ST_FINISH) && (!out_valid || out_ready);
  assign div_start = (state == ST_DIV) && (ph == 2'd1);

  kpv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rda),
    .den   (pv),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    dtu      = timestamp - prev_time;
    mag      = rda[DATA_W-1] ? (DATA_W+1)'(0) - (DATA_W+1)'(rda) : (DATA_W+1)'(rda);
    zdiff    = 33'(y[k]) - 33'(pre[k]);
    ident_ik = (i == k) ? FX_ONE : '0;
    imk      = 33'(ident_ik) - 33'(rda);
    rnoise   = {10'b0, (i < 3'd3) ? position_noise : velocity_noise};
    rsum     = prod + HALF64;
    rsh      = rsum >>> FRAC_BITS;
    rp       = rsh[ACC_W-1:0];
    acc_sat  = sat32(SAT_W'(acc));
    rn       = r + 3'd1;
    if (rn == c) rn = rn + 3'd1;
  end

  // Per-state operand routing for the shared multiply-accumulate unit.
  always_comb begin
    eng       = 1'b0;
    dest_mem  = 1'b0;
    sub       = 1'b0;
    ilast     = 3'd5;
    jlast     = 4'd0;
    klast     = 3'd0;
    follow    = ST_IDLE;
    addr_a    = '0;
    addr_b    = '0;
    dest_addr = '0;
    op_a      = '0;
    op_b      = '0;
    init_val  = '0;
    unique case (state)
      ST_PRED: begin
        eng    = 1'b1;
        follow = ST_MM_AP;
        op_a   = dt;
        if (i < 3'd3) begin
          op_b     = x[3'(i + 3'd3)];
          init_val = 34'(x[i]) + 34'(u[i[1:0]]);
        end else begin
          op_b     = u[2'(i - 3'd3)];
          init_val = 34'(x[i]);
        end
      end
      ST_MM_AP: begin
        eng       = 1'b1;
        dest_mem  = 1'b1;
        jlast     = 4'd5;
        klast     = 3'd5;
        follow    = ST_MM_PAT;
        addr_b    = mat_addr(P_BASE, k, j, 1'b0);
        op_a      = amat(i, k, dt);
        op_b      = rdb;
        dest_addr = mat_addr(T1_BASE, i, j, 1'b0);
      end
      ST_MM_PAT: begin
        eng       = 1'b1;
        dest_mem  = 1'b1;
        jlast     = 4'd5;
        klast     = 3'd5;
        follow    = ST_ADDQ;
        addr_a    = mat_addr(T1_BASE, i, {1'b0, k}, 1'b0);
        op_a      = rda;
        op_b      = amat(j[2:0], k, dt);
        dest_addr = mat_addr(PP_BASE, i, j, 1'b0);
      end
      ST_ADDQ: begin
        eng       = 1'b1;
        dest_mem  = 1'b1;
        follow    = ST_BUILD;
        addr_a    = mat_addr(PP_BASE, i, {1'b0, i}, 1'b0);
        init_val  = 34'(rda) + 34'({1'b0, process_noise});
        dest_addr = addr_a;
      end
      ST_BUILD: begin
        eng       = 1'b1;
        dest_mem  = 1'b1;
        jlast     = 4'd11;
        follow    = ST_PIV;
        addr_a    = mat_addr(PP_BASE, i, j, 1'b0);
        if (j < 4'd6) init_val = 34'(rda) + ((i == j[2:0]) ? rnoise : 34'sd0);
        else init_val = (j - 4'd6 == {1'b0, i}) ? 34'(FX_ONE) : 34'sd0;
        dest_addr = mat_addr(AUG_BASE, i, j, 1'b1);
      end
      ST_ELIM: begin
        eng       = 1'b1;
        dest_mem  = 1'b1;
        sub       = 1'b1;
        ilast     = 3'd0;
        jlast     = 4'd11;
        addr_a    = mat_addr(AUG_BASE, r, j, 1'b1);
        addr_b    = mat_addr(AUG_BASE, c, j, 1'b1);
        op_a      = f;
        op_b      = rdb;
        init_val  = 34'(rda);
        dest_addr = addr_a;
      end
      ST_MM_K: begin
        eng       = 1'b1;
        dest_mem  = 1'b1;
        jlast     = 4'd5;
        klast     = 3'd5;
        follow    = ST_XUPD;
        addr_a    = mat_addr(PP_BASE, i, {1'b0, k}, 1'b0);
        addr_b    = mat_addr(AUG_BASE, k, j + 4'd6, 1'b1);
        op_a      = rda;
        // A singular innovation gives an all-zero inverse and so a zero gain.
        op_b      = singular ? '0 : rdb;
        dest_addr = mat_addr(K_BASE, i, j, 1'b0);
      end
      ST_XUPD: begin
        eng      = 1'b1;
        klast    = 3'd5;
        follow   = ST_MM_P;
        addr_a   = mat_addr(K_BASE, i, {1'b0, k}, 1'b0);
        op_a     = rda;
        op_b     = sat32(SAT_W'(zdiff));
        init_val = 34'(pre[i]);
      end
      ST_MM_P: begin
        eng       = 1'b1;
        dest_mem  = 1'b1;
        jlast     = 4'd5;
        klast     = 3'd5;
        follow    = ST_FINISH;
        addr_a    = mat_addr(K_BASE, i, {1'b0, k}, 1'b0);
        addr_b    = mat_addr(PP_BASE, k, j, 1'b0);
        op_a      = sat32(SAT_W'(imk));
        op_b      = rdb;
        dest_addr = mat_addr(P_BASE, i, j, 1'b0);
      end
      ST_PIV, ST_ELIM_F: begin
        addr_a = mat_addr(AUG_BASE, r, {1'b0, c}, 1'b1);
      end
      ST_SWAP: begin
        addr_a = mat_addr(AUG_BASE, c, j, 1'b1);
        addr_b = mat_addr(AUG_BASE, best, j, 1'b1);
      end
      ST_DIV: begin
        addr_a = mat_addr(AUG_BASE, c, j, 1'b1);
      end
      ST_CLEAR, ST_IDLE, ST_FINISH: begin
      end
    endcase
  end

  // Memory write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dest_addr;
    wr_data = acc_sat;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = mat_addr(P_BASE, i, j, 1'b0);
      wr_data = (j == {1'b0, i}) ? FX_ONE : '0;
    end else if (eng && dest_mem && ph == 2'd3) begin
      wr_en = 1'b1;
    end else if (state == ST_SWAP && ph == 2'd1) begin
      wr_en   = 1'b1;
      wr_addr = mat_addr(AUG_BASE, c, j, 1'b1);
      wr_data = rdb;
    end else if (state == ST_SWAP && ph == 2'd2) begin
      wr_en   = 1'b1;
      wr_addr = mat_addr(AUG_BASE, best, j, 1'b1);
      wr_data = hold;
    end else if (state == ST_DIV && ph == 2'd2 && div_done) begin
      wr_en   = 1'b1;
      wr_addr = mat_addr(AUG_BASE, c, j, 1'b1);
      wr_data = div_q;
    end
  end

  // Sequencer: next state and loop counters.
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    ph_next    = ph;
    c_next     = c;
    r_next     = r;
    unique case (state)
      ST_CLEAR: begin
        if (j == 4'd5) begin
          j_next = '0;
          if (i == 3'd5) begin
            i_next     = '0;
            state_next = ST_IDLE;
          end else begin
            i_next = i + 3'd1;
          end
        end else begin
          j_next = j + 4'd1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_PRED;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          ph_next    = '0;
        end
      end
      ST_PRED, ST_MM_AP, ST_MM_PAT, ST_ADDQ, ST_BUILD, ST_ELIM, ST_MM_K, ST_XUPD,
      ST_MM_P: begin
        unique case (ph)
          2'd0: ph_next = 2'd1;
          2'd1: ph_next = 2'd2;
          2'd2: begin
            if (k == klast) begin
              ph_next = 2'd3;
            end else begin
              k_next  = k + 3'd1;
              ph_next = 2'd0;
            end
          end
          2'd3: begin
            k_next  = '0;
            ph_next = 2'd0;
            if (j == jlast) begin
              j_next = '0;
              if (i == ilast) begin
                i_next = '0;
                if (state == ST_ELIM) begin
                  if (rn > 3'd5) begin
                    if (c == 3'd5) begin
                      state_next = ST_MM_K;
                    end else begin
                      c_next     = c + 3'd1;
                      r_next     = c + 3'd1;
                      state_next = ST_PIV;
                    end
                  end else begin
                    r_next     = rn;
                    state_next = ST_ELIM_F;
                  end
                end else begin
                  state_next = follow;
                  if (state == ST_BUILD) begin
                    c_next = '0;
                    r_next = '0;
                  end
                end
              end else begin
                i_next = i + 3'd1;
              end
            end else begin
              j_next = j + 4'd1;
            end
          end
        endcase
      end
      ST_PIV: begin
        unique case (ph)
          2'd0: ph_next = 2'd1;
          2'd1: begin
            if (r == 3'd5) begin
              ph_next = 2'd2;
            end else begin
              r_next  = r + 3'd1;
              ph_next = 2'd0;
            end
          end
          2'd2, 2'd3: begin
            ph_next = 2'd0;
            j_next  = '0;
            if (bestmag == '0) state_next = ST_MM_K;
            else if (best != c) state_next = ST_SWAP;
            else state_next = ST_DIV;
          end
        endcase
      end
      ST_SWAP: begin
        unique case (ph)
          2'd0: ph_next = 2'd1;
          2'd1: ph_next = 2'd2;
          2'd2, 2'd3: begin
            ph_next = 2'd0;
            if (j == 4'd11) begin
              j_next     = '0;
              state_next = ST_DIV;
            end else begin
              j_next = j + 4'd1;
            end
          end
        endcase
      end
      ST_DIV: begin
        unique case (ph)
          2'd0: ph_next = 2'd1;
          2'd1: ph_next = 2'd2;
          2'd2, 2'd3: begin
            if (div_done) begin
              ph_next = 2'd0;
              if (j == 4'd11) begin
                j_next     = '0;
                r_next     = (c == 3'd0) ? 3'd1 : 3'd0;
                state_next = ST_ELIM_F;
              end else begin
                j_next = j + 4'd1;
              end
            end
          end
        endcase
      end
      ST_ELIM_F: begin
        if (ph == 2'd0) begin
          ph_next = 2'd1;
        end else begin
          ph_next    = 2'd0;
          j_next     = '0;
          state_next = ST_ELIM;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      ph    <= '0;
      c     <= '0;
      r     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      ph    <= ph_next;
      c     <= c_next;
      r     <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rda <= mem[addr_a];
    rdb <= mem[addr_b];
  end

  // Multiply-accumulate datapath and scratch registers.
  always_ff @(posedge clk) begin
    if (eng && ph == 2'd1) begin
      prod <= 64'(op_a) * 64'(op_b);
      if (k == 3'd0) acc <= ACC_W'(init_val);
    end
    if (eng && ph == 2'd2) acc <= sub ? acc - rp : acc + rp;
    if (state == ST_PRED && ph == 2'd3) pre[i] <= acc_sat;
    if (state == ST_PIV && ph == 2'd1 && (r == c || mag > bestmag)) begin
      best    <= r;
      bestmag <= mag;
      pv      <= rda;
    end
    if (state == ST_SWAP && ph == 2'd1) hold <= rda;
    if (state == ST_ELIM_F && ph == 2'd1) f <= rda;
    if (in_acc) begin
      tcur <= timestamp;
      dt   <= dtu[DATA_W-1] ? 32'sh7FFFFFFF : $signed(dtu);
      y[0] <= pos_x;
      y[1] <= pos_y;
      y[2] <= pos_z;
      y[3] <= vel_x;
      y[4] <= vel_y;
      y[5] <= vel_z;
      u[0] <= acc_x;
      u[1] <= acc_y;
      u[2] <= acc_z;
    end
    if (out_load) begin
      out_time  <= tcur;
      est_pos_x <= x[0];
      est_pos_y <= x[1];
      est_pos_z <= x[2];
      est_vel_x <= x[3];
      est_vel_y <= x[4];
      est_vel_z <= x[5];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time      <= '0;
      singular       <= 1'b0;
      out_valid      <= 1'b0;
      process_noise  <= RESET_Q;
      position_noise <= RESET_R;
      velocity_noise <= RESET_R;
      for (int n = 0; n < MAT_N; n++) x[n] <= '0;
    end else begin
      if (in_acc) begin
        prev_time <= timestamp;
        singular  <= 1'b0;
      end
      if (state == ST_PIV && ph == 2'd2 && bestmag == '0) singular <= 1'b1;
      if (state == ST_XUPD && ph == 2'd3) x[i] <= acc_sat;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROCESS_NOISE:  process_noise  <= cfg_data;
          REG_POSITION_NOISE: position_noise <= cfg_data;
          REG_VELOCITY_NOISE: velocity_noise <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_PRED)
    else $error("accepted word did not start the prediction");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && out_time == $past(tcur))
    else $error("result register not loaded at finish");

  a_singular_skips: assert property (@(posedge clk) disable iff (rst)
    singular |-> !(state == ST_PIV || state == ST_SWAP || state == ST_DIV ||
                   state == ST_ELIM_F || state == ST_ELIM))
    else $error("inversion continued after a zero pivot column");

  a_elim_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ELIM && wr_en) |-> r != c)
    else $error("elimination wrote the pivot row");

endmodule
